// ===== hw/rtl/gcs_pkg.sv =====
// Shared types and constants of the gantry crane sequencer.
package gcs_pkg;

   localparam int unsigned DriveW = 8;
   localparam int unsigned CfgDriveW = 7;
   localparam int unsigned ArmW = 4;
   localparam int unsigned RotW = 4;
   localparam int unsigned ModeW = 3;
   localparam int unsigned LedCount = 7;
   localparam int unsigned DriveMax = 100;
   localparam int unsigned RotMax = 15;

   localparam logic [ModeW-1:0] MODE_SELECT_X = 3'd0;
   localparam logic [ModeW-1:0] MODE_SELECT_Y = 3'd1;
   localparam logic [ModeW-1:0] MODE_TRAVEL = 3'd2;
   localparam logic [ModeW-1:0] MODE_LIFT = 3'd3;
   localparam logic [ModeW-1:0] MODE_RETURN = 3'd4;
   localparam logic [ModeW-1:0] MODE_FETCH = 3'd5;
   localparam logic [ModeW-1:0] MODE_EMERGENCY = 3'd6;

   localparam logic [1:0] REG_TRAVEL_DRIVE = 2'd0;
   localparam logic [1:0] REG_RETURN_DRIVE = 2'd1;
   localparam logic [1:0] REG_LIFT_DRIVE = 2'd2;
   localparam logic [1:0] REG_ARM_COUNT = 2'd3;

   localparam logic [CfgDriveW-1:0] TRAVEL_DRIVE_RESET = 7'd30;
   localparam logic [CfgDriveW-1:0] RETURN_DRIVE_RESET = 7'd60;
   localparam logic [CfgDriveW-1:0] LIFT_DRIVE_RESET = 7'd60;
   localparam logic [ArmW-1:0] ARM_COUNT_RESET = 4'd2;

   localparam int unsigned L_START = 0;
   localparam int unsigned L_RESET = 1;
   localparam int unsigned L_ENCR = 2;
   localparam int unsigned L_ENCL = 3;
   localparam int unsigned L_ROTX = 4;
   localparam int unsigned L_ROTY = 5;
   localparam int unsigned LevelW = 6;

   typedef struct packed {
      logic start_button;
      logic reset_button;
      logic emergency_stop;
      logic encoder_right;
      logic encoder_left;
      logic limit_x;
      logic limit_y;
      logic z_top_switch;
      logic z_bottom_switch;
      logic rotation_x;
      logic rotation_y;
   } req_type;

   typedef struct packed {
      logic [ModeW-1:0] mode;
      logic signed [DriveW-1:0] drive_x;
      logic signed [DriveW-1:0] drive_y;
      logic signed [DriveW-1:0] drive_z;
      logic [LedCount-1:0] x_led_mask;
      logic [LedCount-1:0] y_led_mask;
      logic relay_on;
   } rsp_type;

endpackage

// ===== hw/rtl/gantry_crane_sequencer.sv =====
// Top level of the gantry crane sequencer: input register, sequencer logic and result register.

// Each transaction is one debounced pin sample; the block returns exactly one result transaction
// for it, through the input register and then the result register. A new sample is taken in
// every cycle while results are taken: the sample sits in an input register, the mode logic
// decides it in one pass and writes the result register and the crane state together, so the
// sustained rate is one transaction per cycle, limited only by how fast results are taken.
module gantry_crane_sequencer
   import gcs_pkg::*;
#(
   parameter int unsigned POSITIONS = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int unsigned PosW = $clog2(POSITIONS);
   localparam logic [PosW-1:0] PosLast = PosW'(POSITIONS - 1);

   logic [CfgDriveW-1:0] travel_drive_ff, return_drive_ff, lift_drive_ff;
   logic [ArmW-1:0] arm_count_ff;

   logic in_valid_ff;
   req_type in_data_ff;
   logic out_valid_ff;
   rsp_type out_data_ff;
   logic advance;

   logic [ModeW-1:0] mode_ff, mode_in;
   logic [PosW-1:0] x_target_ff, x_target_in, y_target_ff, y_target_in;
   logic [RotW-1:0] rot_x_ff, rot_x_in, rot_y_ff, rot_y_in;
   logic xdone_ff, xdone_in, ydone_ff, ydone_in, xarm_ff, xarm_in;
   logic yarm_ff, yarm_in, zarm_ff, zarm_in, yled_ff, yled_in;
   logic signed [DriveW-1:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic relay_ff, relay_in;
   logic [LevelW-1:0] prev_ff, now_levels, clicks;
   rsp_type out_data_in;

   function automatic logic signed [DriveW-1:0] sat_drive(input logic [CfgDriveW-1:0] v);
      logic [CfgDriveW-1:0] s;
      s = (v > CfgDriveW'(DriveMax)) ? CfgDriveW'(DriveMax) : v;
      return signed'({1'b0, s});
   endfunction

   function automatic logic [PosW-1:0] move_pos(input logic [PosW-1:0] p, input logic up,
                                                input logic down);
      logic [PosW:0] inc;
      logic [PosW-1:0] r;
      inc = {1'b0, p} + (PosW+1)'(1);
      r = p;
      if (up && !down) begin
         r = (inc >= (PosW+1)'(POSITIONS)) ? '0 : inc[PosW-1:0];
      end else if (down && !up) begin
         r = (p == '0) ? PosLast : p - PosW'(1);
      end
      return r;
   endfunction

   function automatic logic [LedCount-1:0] led_mask(input logic [PosW-1:0] p);
      logic [LedCount-1:0] m;
      for (int i = 0; i < LedCount; i++) begin
         m[i] = (int'(p) == i);
      end
      return m;
   endfunction

   // Configuration registers.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         travel_drive_ff <= TRAVEL_DRIVE_RESET;
         return_drive_ff <= RETURN_DRIVE_RESET;
         lift_drive_ff <= LIFT_DRIVE_RESET;
         arm_count_ff <= ARM_COUNT_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[3:2])
            REG_TRAVEL_DRIVE: travel_drive_ff <= pwdata[CfgDriveW-1:0];
            REG_RETURN_DRIVE: return_drive_ff <= pwdata[CfgDriveW-1:0];
            REG_LIFT_DRIVE: lift_drive_ff <= pwdata[CfgDriveW-1:0];
            REG_ARM_COUNT: arm_count_ff <= pwdata[ArmW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TRAVEL_DRIVE: prdata = 32'(travel_drive_ff);
         REG_RETURN_DRIVE: prdata = 32'(return_drive_ff);
         REG_LIFT_DRIVE: prdata = 32'(lift_drive_ff);
         REG_ARM_COUNT: prdata = 32'(arm_count_ff);
         default: prdata = '0;
      endcase
   end

   // Handshake and pipeline registers.
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // Sequencer logic for the sample in the input register.
   always_comb begin
      logic signed [DriveW-1:0] lift;
      logic signed [DriveW-1:0] ret;
      logic estop;
      lift = sat_drive(lift_drive_ff);
      ret = -sat_drive(return_drive_ff);
      estop = in_data_ff.emergency_stop;

      now_levels = '0;
      now_levels[L_START] = in_data_ff.start_button;
      now_levels[L_RESET] = in_data_ff.reset_button;
      now_levels[L_ENCR] = in_data_ff.encoder_right;
      now_levels[L_ENCL] = in_data_ff.encoder_left;
      now_levels[L_ROTX] = in_data_ff.rotation_x;
      now_levels[L_ROTY] = in_data_ff.rotation_y;
      clicks = prev_ff & ~now_levels;

      mode_in = estop ? MODE_EMERGENCY : mode_ff;
      x_target_in = x_target_ff;
      y_target_in = y_target_ff;
      rot_x_in = rot_x_ff;
      rot_y_in = rot_y_ff;
      xdone_in = xdone_ff;
      ydone_in = ydone_ff;
      xarm_in = xarm_ff;
      yarm_in = yarm_ff;
      zarm_in = zarm_ff;
      yled_in = yled_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      dz_in = dz_ff;
      relay_in = relay_ff;

      case (mode_in)
         MODE_SELECT_X: begin
            dx_in = '0;
            dy_in = '0;
            dz_in = '0;
            x_target_in = move_pos(x_target_ff, clicks[L_ENCR], clicks[L_ENCL]);
            if (clicks[L_START]) begin
               mode_in = MODE_SELECT_Y;
            end
         end
         MODE_SELECT_Y: begin
            y_target_in = move_pos(y_target_ff, clicks[L_ENCR], clicks[L_ENCL]);
            yled_in = 1'b1;
            if (clicks[L_START]) begin
               dx_in = sat_drive(travel_drive_ff);
               dy_in = sat_drive(travel_drive_ff);
               rot_x_in = '0;
               rot_y_in = '0;
               xdone_in = 1'b0;
               ydone_in = 1'b0;
               xarm_in = 1'b0;
               yarm_in = 1'b0;
               zarm_in = 1'b0;
               mode_in = MODE_TRAVEL;
            end
            if (clicks[L_RESET]) begin
               mode_in = MODE_SELECT_X;
            end
         end
         MODE_TRAVEL: begin
            if (clicks[L_ROTX] && rot_x_ff < RotW'(RotMax)) begin
               rot_x_in = rot_x_ff + RotW'(1);
            end
            if (clicks[L_ROTY] && rot_y_ff < RotW'(RotMax)) begin
               rot_y_in = rot_y_ff + RotW'(1);
            end
            if (RotW'(x_target_ff) == rot_x_in) begin
               dx_in = '0;
               xdone_in = 1'b1;
            end
            if (RotW'(y_target_ff) == rot_y_in) begin
               dy_in = '0;
               ydone_in = 1'b1;
            end
            if (rot_x_in == arm_count_ff) begin
               xarm_in = 1'b1;
            end
            if (rot_y_in == arm_count_ff) begin
               yarm_in = 1'b1;
            end
            if (in_data_ff.limit_x && xarm_in) begin
               dx_in = '0;
               xarm_in = 1'b0;
            end
            if (in_data_ff.limit_y && yarm_in) begin
               dy_in = '0;
               yarm_in = 1'b0;
            end
            if (clicks[L_RESET]) begin
               dx_in = ret;
               dy_in = ret;
               rot_x_in = '0;
               rot_y_in = '0;
               xdone_in = 1'b0;
               ydone_in = 1'b0;
               xarm_in = 1'b0;
               yarm_in = 1'b0;
               zarm_in = 1'b0;
               mode_in = MODE_RETURN;
            end
            if (xdone_in && ydone_in) begin
               dz_in = lift;
               mode_in = MODE_LIFT;
            end
         end
         MODE_LIFT: begin
            if (in_data_ff.z_bottom_switch) begin
               zarm_in = 1'b1;
               dz_in = -lift;
            end
            if (zarm_in && in_data_ff.z_top_switch) begin
               dz_in = '0;
               dx_in = ret;
               dy_in = ret;
               rot_x_in = '0;
               rot_y_in = '0;
               xdone_in = 1'b0;
               ydone_in = 1'b0;
               xarm_in = 1'b0;
               yarm_in = 1'b0;
               zarm_in = 1'b0;
               mode_in = MODE_RETURN;
            end
         end
         MODE_RETURN: begin
            if (in_data_ff.limit_x) begin
               dx_in = '0;
               xarm_in = 1'b1;
            end
            if (in_data_ff.limit_y) begin
               dy_in = '0;
               yarm_in = 1'b1;
            end
            if (xarm_in && yarm_in) begin
               xarm_in = 1'b0;
               yarm_in = 1'b0;
               dz_in = lift;
               mode_in = MODE_FETCH;
            end
         end
         MODE_FETCH: begin
            if (in_data_ff.z_bottom_switch) begin
               relay_in = 1'b1;
               zarm_in = 1'b1;
               dz_in = -lift;
            end
            if (zarm_in && in_data_ff.z_top_switch) begin
               dz_in = '0;
               zarm_in = 1'b0;
               mode_in = MODE_SELECT_X;
            end
         end
         default: begin
            relay_in = 1'b1;
            if (!estop) begin
               relay_in = 1'b0;
               mode_in = MODE_SELECT_X;
            end
         end
      endcase

      out_data_in.mode = mode_in;
      out_data_in.drive_x = dx_in;
      out_data_in.drive_y = dy_in;
      out_data_in.drive_z = dz_in;
      out_data_in.x_led_mask = led_mask(x_target_in);
      out_data_in.y_led_mask = yled_in ? led_mask(y_target_in) : '0;
      out_data_in.relay_on = relay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SELECT_X;
         x_target_ff <= '0;
         y_target_ff <= '0;
         rot_x_ff <= '0;
         rot_y_ff <= '0;
         xdone_ff <= 1'b0;
         ydone_ff <= 1'b0;
         xarm_ff <= 1'b0;
         yarm_ff <= 1'b0;
         zarm_ff <= 1'b0;
         yled_ff <= 1'b0;
         dx_ff <= '0;
         dy_ff <= '0;
         dz_ff <= '0;
         relay_ff <= 1'b0;
         prev_ff <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         x_target_ff <= x_target_in;
         y_target_ff <= y_target_in;
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
         xdone_ff <= xdone_in;
         ydone_ff <= ydone_in;
         xarm_ff <= xarm_in;
         yarm_ff <= yarm_in;
         zarm_ff <= zarm_in;
         yled_ff <= yled_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
         relay_ff <= relay_in;
         prev_ff <= now_levels;
      end
   end

   // An emergency stop in a sample always yields an emergency result.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_data_ff.emergency_stop |=> out_data_ff.mode == MODE_EMERGENCY)
      else $error("emergency stop did not force the emergency mode");

   // The LED rows show at most one position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_data.x_led_mask) && $onehot0(rsp_data.y_led_mask))
      else $error("LED mask has more than one bit set");

   // Drives stay within full scale in both directions.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.drive_x <= 8'sd100 && rsp_data.drive_x >= -8'sd100
                 && rsp_data.drive_y <= 8'sd100 && rsp_data.drive_y >= -8'sd100
                 && rsp_data.drive_z <= 8'sd100 && rsp_data.drive_z >= -8'sd100)
      else $error("drive out of range");

   // A processed sample always produces a valid result in the result register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed sample produced no result");

endmodule
